>>> design/sgb_pkg.sv
// sgb_pkg: shared types and constants of the separable gaussian blur core
// field widths, register indexes, reset values and sequencer states
// no dependencies
`timescale 1ns / 1ps

package sgb_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int MAX_HALF_DEF   = 4;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 10;
    localparam int DIM_W      = 11;
    localparam int HALF_W     = 3;
    localparam int COEF_W     = 16;
    localparam int FRAC_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_COEF   = 5;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);
    localparam int PROD_W     = PIX_W + COEF_W;

    localparam logic [FRAC_W-1:0] ROUND_HALF = FRAC_W'(32768);

    localparam logic [DIM_W-1:0]  RST_FRAME_WIDTH  = DIM_W'(1024);
    localparam logic [DIM_W-1:0]  RST_FRAME_HEIGHT = DIM_W'(1024);
    localparam logic [HALF_W-1:0] RST_KERNEL_HALF  = HALF_W'(1);
    localparam logic [COEF_W-1:0] RST_COEF_CENTER  = COEF_W'(32768);
    localparam logic [COEF_W-1:0] RST_COEF_OFF1    = COEF_W'(16384);
    localparam logic [COEF_W-1:0] RST_COEF_OFF_HI  = COEF_W'(0);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_KERNEL_HALF  = 3'd2,
        CFG_COEF_CENTER  = 3'd3,
        CFG_COEF_OFF1    = 3'd4,
        CFG_COEF_OFF2    = 3'd5,
        CFG_COEF_OFF3    = 3'd6,
        CFG_COEF_OFF4    = 3'd7
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HROW,
        S_HTAP,
        S_HDR1,
        S_HDR2,
        S_HRND,
        S_VMUL,
        S_VACC,
        S_RESULT
    } t_state;

endpackage

>>> design/sgb_ram.sv
// sgb_ram: generic simple dual port ram, one write and one registered read port
// used for the frame store; no dependencies
`timescale 1ns / 1ps

module sgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/separable_gaussian_blur_core.sv
// separable_gaussian_blur_core: frame store with a separable clamped-border blur
// load: stores one in-range pixel, no result. query: one horizontal pass per kernel row; one
// 8x16 multiplier is shared by all taps, one frame store read per cycle
// out-of-frame query: skips the blur, zero result. one item at a time, stall high while busy
// sync active-low reset restores the config registers and idles the sequencer; the frame
// store is not cleared. uses sgb_pkg and sgb_ram
`timescale 1ns / 1ps

module separable_gaussian_blur_core #(
    parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sgb_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_HALF   = sgb_pkg::MAX_HALF_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config port
    input  logic                           i_cfg_we,
    input  logic [sgb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [sgb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_mode,
    input  logic [sgb_pkg::PIX_W-1:0]      i_pixel_in,
    input  logic [sgb_pkg::COORD_W-1:0]    i_col,
    input  logic [sgb_pkg::COORD_W-1:0]    i_row,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [sgb_pkg::PIX_W-1:0]      o_blurred,
    output logic                           o_out_of_frame
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int DWX   = $clog2(MAX_WIDTH + 1);
    localparam int DWY   = $clog2(MAX_HEIGHT + 1);
    localparam int MW0   = (DWX > DWY) ? DWX : DWY;
    localparam int MW1   = (MW0 > sgb_pkg::DIM_W) ? MW0 : sgb_pkg::DIM_W;
    localparam int CW    = MW1 + 2;
    localparam int HW    = $clog2(MAX_HALF + 1);
    localparam int IW    = $clog2(2 * MAX_HALF + 1);
    localparam int ACC_W = sgb_pkg::PROD_W + $clog2(2 * MAX_HALF + 1);
    localparam int PW    = sgb_pkg::PIX_W;

    // rounds half up and saturates to one pixel
    function automatic logic [PW-1:0] round_sat(input logic [ACC_W-1:0] acc);
        logic [ACC_W:0] s;
        s = (ACC_W+1)'(acc) + (ACC_W+1)'(sgb_pkg::ROUND_HALF);
        if (|s[ACC_W:sgb_pkg::FRAC_W+PW]) begin
            return {PW{1'b1}};
        end
        return s[sgb_pkg::FRAC_W+PW-1:sgb_pkg::FRAC_W];
    endfunction

    sgb_pkg::t_state r_state, n_state;

    logic [sgb_pkg::DIM_W-1:0]  r_cfg_width;
    logic [sgb_pkg::DIM_W-1:0]  r_cfg_height;
    logic [sgb_pkg::HALF_W-1:0] r_cfg_half;
    logic [sgb_pkg::COEF_W-1:0] r_coef [sgb_pkg::NUM_COEF];

    logic [sgb_pkg::COORD_W-1:0] r_col, r_row;
    logic [DWX-1:0]              r_w;
    logic [DWY-1:0]              r_hgt;
    logic [HW-1:0]               r_h;
    logic [IW-1:0]               r_hi, r_vi;
    logic [AW-1:0]               r_row_base;
    logic [AW-1:0]               r_raddr;
    logic                        r_p1_vld, r_p2_vld;
    logic [sgb_pkg::COEF_W-1:0]  r_p1_coef, r_p2_coef;
    logic [sgb_pkg::PROD_W-1:0]  r_prod;
    logic [ACC_W-1:0]            r_hacc, r_vacc;
    logic [PW-1:0]               r_hval;
    logic                        r_oof;
    logic                        r_out_valid;
    logic [PW-1:0]               r_blurred;
    logic                        r_out_oof;

    logic                       in_acc, out_free, ram_we, load_ok, q_oof;
    logic [AW-1:0]              waddr;
    logic [PW-1:0]              rdata;
    logic [CW-1:0]              w_eff, hgt_eff;
    logic [HW-1:0]              h_eff;
    logic [IW-1:0]              two_h, sel_idx, tap_dist;
    logic [sgb_pkg::COEF_W-1:0] weight;
    logic [CW-1:0]              sx, sy;
    logic [XW-1:0]              cx;
    logic [YW-1:0]              cy;
    logic [PW-1:0]              mult_a;
    logic [sgb_pkg::COEF_W-1:0] mult_b;
    logic [sgb_pkg::PROD_W-1:0] mult_p;

    // effective frame size and half width from the registers
    always_comb begin
        if (r_cfg_width == '0) begin
            w_eff = CW'(1);
        end else if (CW'(r_cfg_width) > CW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            hgt_eff = CW'(1);
        end else if (CW'(r_cfg_height) > CW'(MAX_HEIGHT)) begin
            hgt_eff = CW'(MAX_HEIGHT);
        end else begin
            hgt_eff = CW'(r_cfg_height);
        end
        if (int'(r_cfg_half) > MAX_HALF) begin
            h_eff = HW'(MAX_HALF);
        end else begin
            h_eff = HW'(r_cfg_half);
        end
    end

    assign q_oof   = (CW'(i_col) >= w_eff) || (CW'(i_row) >= hgt_eff);
    assign load_ok = (int'(i_col) < MAX_WIDTH) && (int'(i_row) < MAX_HEIGHT);
    assign waddr   = AW'(i_row) * AW'(MAX_WIDTH) + AW'(i_col);
    assign out_free = !r_out_valid || !i_out_stall;

    // tap weight: one coefficient read, by column tap or by row tap
    assign two_h    = IW'(r_h) + IW'(r_h);
    assign sel_idx  = (r_state == sgb_pkg::S_VMUL) ? r_vi : r_hi;
    assign tap_dist = (sel_idx >= IW'(r_h)) ? (sel_idx - IW'(r_h)) : (IW'(r_h) - sel_idx);
    assign weight   = (int'(tap_dist) < sgb_pkg::NUM_COEF) ?
                      r_coef[sgb_pkg::COEF_IDX_W'(tap_dist)] : '0;

    // clamped tap coordinates, sign bit marks a position left of or above the frame
    always_comb begin
        sx = CW'(r_col) + CW'(r_hi) - CW'(r_h);
        sy = CW'(r_row) + CW'(r_vi) - CW'(r_h);
        if (sx[CW-1]) begin
            cx = '0;
        end else if (sx >= CW'(r_w)) begin
            cx = XW'(r_w - DWX'(1));
        end else begin
            cx = XW'(sx);
        end
        if (sy[CW-1]) begin
            cy = '0;
        end else if (sy >= CW'(r_hgt)) begin
            cy = YW'(r_hgt - DWY'(1));
        end else begin
            cy = YW'(sy);
        end
    end

    // shared multiplier; column weights pass through r_p1_coef and r_p2_coef to meet the ram data
    assign mult_a = (r_state == sgb_pkg::S_VMUL) ? r_hval : rdata;
    assign mult_b = (r_state == sgb_pkg::S_VMUL) ? weight : r_p2_coef;
    assign mult_p = sgb_pkg::PROD_W'(mult_a) * sgb_pkg::PROD_W'(mult_b);

    sgb_ram #(
        .WIDTH (PW),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (waddr),
        .i_wdata (i_pixel_in),
        .i_raddr (r_raddr),
        .o_rdata (rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sgb_pkg::S_IDLE: begin
                if (i_in_valid && i_mode) begin
                    n_state = q_oof ? sgb_pkg::S_RESULT : sgb_pkg::S_HROW;
                end
            end
            sgb_pkg::S_HROW: n_state = sgb_pkg::S_HTAP;
            sgb_pkg::S_HTAP: begin
                if (r_hi == two_h) begin
                    n_state = sgb_pkg::S_HDR1;
                end
            end
            sgb_pkg::S_HDR1: n_state = sgb_pkg::S_HDR2;
            sgb_pkg::S_HDR2: n_state = sgb_pkg::S_HRND;
            sgb_pkg::S_HRND: n_state = sgb_pkg::S_VMUL;
            sgb_pkg::S_VMUL: n_state = sgb_pkg::S_VACC;
            sgb_pkg::S_VACC: begin
                n_state = (r_vi == two_h) ? sgb_pkg::S_RESULT : sgb_pkg::S_HROW;
            end
            sgb_pkg::S_RESULT: begin
                if (out_free) begin
                    n_state = sgb_pkg::S_IDLE;
                end
            end
            default: n_state = sgb_pkg::S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_in_stall = (r_state != sgb_pkg::S_IDLE);
        in_acc     = i_in_valid && (r_state == sgb_pkg::S_IDLE);
        ram_we     = in_acc && !i_mode && load_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sgb_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            r_cfg_width  <= sgb_pkg::RST_FRAME_WIDTH;
            r_cfg_height <= sgb_pkg::RST_FRAME_HEIGHT;
            r_cfg_half   <= sgb_pkg::RST_KERNEL_HALF;
            r_coef[0]    <= sgb_pkg::RST_COEF_CENTER;
            r_coef[1]    <= sgb_pkg::RST_COEF_OFF1;
            r_coef[2]    <= sgb_pkg::RST_COEF_OFF_HI;
            r_coef[3]    <= sgb_pkg::RST_COEF_OFF_HI;
            r_coef[4]    <= sgb_pkg::RST_COEF_OFF_HI;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= (r_state == sgb_pkg::S_HTAP);
            r_p2_vld <= r_p1_vld;
            if (i_cfg_we) begin
                unique case (sgb_pkg::t_cfg_idx'(i_cfg_idx))
                    sgb_pkg::CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data[sgb_pkg::DIM_W-1:0];
                    sgb_pkg::CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data[sgb_pkg::DIM_W-1:0];
                    sgb_pkg::CFG_KERNEL_HALF:  r_cfg_half   <= i_cfg_data[sgb_pkg::HALF_W-1:0];
                    sgb_pkg::CFG_COEF_CENTER:  r_coef[0]    <= i_cfg_data;
                    sgb_pkg::CFG_COEF_OFF1:    r_coef[1]    <= i_cfg_data;
                    sgb_pkg::CFG_COEF_OFF2:    r_coef[2]    <= i_cfg_data;
                    sgb_pkg::CFG_COEF_OFF3:    r_coef[3]    <= i_cfg_data;
                    sgb_pkg::CFG_COEF_OFF4:    r_coef[4]    <= i_cfg_data;
                endcase
            end
            if (r_state == sgb_pkg::S_RESULT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod    <= mult_p;
        r_p1_coef <= weight;
        r_p2_coef <= r_p1_coef;
        if (r_p2_vld) begin
            r_hacc <= r_hacc + ACC_W'(mult_p);
        end
        unique case (r_state)
            sgb_pkg::S_IDLE: begin
                if (in_acc && i_mode) begin
                    r_oof  <= q_oof;
                    r_col  <= i_col;
                    r_row  <= i_row;
                    r_w    <= DWX'(w_eff);
                    r_hgt  <= DWY'(hgt_eff);
                    r_h    <= h_eff;
                    r_vi   <= '0;
                    r_vacc <= '0;
                end
            end
            sgb_pkg::S_HROW: begin
                r_row_base <= AW'(cy) * AW'(MAX_WIDTH);
                r_hacc     <= '0;
                r_hi       <= '0;
            end
            sgb_pkg::S_HTAP: begin
                r_raddr <= r_row_base + AW'(cx);
                r_hi    <= r_hi + IW'(1);
            end
            sgb_pkg::S_HRND: begin
                r_hval <= round_sat(r_hacc);
            end
            sgb_pkg::S_VACC: begin
                r_vacc <= r_vacc + ACC_W'(r_prod);
                r_vi   <= r_vi + IW'(1);
            end
            sgb_pkg::S_RESULT: begin
                if (out_free) begin
                    r_out_oof <= r_oof;
                    r_blurred <= r_oof ? '0 : round_sat(r_vacc);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_blurred      = r_blurred;
    assign o_out_of_frame = r_out_oof;

endmodule
